// ===== rtl/cbrf_pkg.sv =====
// Package for the cubic bisection root finder.
// Holds field widths, transaction structs, register indexes and state encodings.
// No dependencies.
package cbrf_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int VAL_W     = 32;
    localparam int TOL_W     = 31;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;

    // Width of one multiplier digit in the shared multiply unit.
    localparam int DIGIT_W = 16;

    // Smallest tolerance used; smaller programmed values are raised to it.
    localparam logic [TOL_W-1:0] TOL_MIN = TOL_W'(2);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUBIC  = 2'd0,
        CFG_LINEAR = 2'd1,
        CFG_CONST  = 2'd2,
        CFG_TOL    = 2'd3
    } cfg_idx_t;

    // Input transaction: search interval.
    typedef struct packed {
        logic signed [VAL_W-1:0] left_end;
        logic signed [VAL_W-1:0] right_end;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic signed [VAL_W-1:0] root;
        logic                    no_bracket;
        logic                    exact_hit;
        logic [CNT_W-1:0]        halvings;
    } out_item_t;

    // Polynomial coefficients as programmed.
    typedef struct packed {
        logic [VAL_W-1:0] cubic;
        logic [VAL_W-1:0] linear;
        logic [VAL_W-1:0] offset;
    } coef_t;

    // Sign of a polynomial value.
    typedef struct packed {
        logic neg;
        logic zero;
    } psign_t;

    // Bisection sequencer states.
    typedef enum logic [2:0] {
        T_IDLE,
        T_EVAL_A,
        T_EVAL_B,
        T_CHECK,
        T_EVAL_C,
        T_DONE
    } top_state_t;

    // Polynomial evaluation sequencer states.
    typedef enum logic [2:0] {
        P_IDLE,
        P_LOAD,
        P_SQ,
        P_CUBE,
        P_ABS,
        P_LIN
    } poly_state_t;

    // Shared multiplier states.
    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_DRAIN,
        M_FIN
    } mul_state_t;

endpackage

// ===== rtl/cbrf_mul.sv =====
// Shared digit-serial multiply-accumulate unit: result = addend +/- a_mag * b_mag.
// The multiplier operand is consumed one digit per cycle, most significant first.
// Depends on cbrf_pkg.
module cbrf_mul #(
    parameter int A_W      = 32,
    parameter int B_W      = 112,
    parameter int P_W      = 131,
    parameter int CNT_BITS = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                neg,
    input  logic [CNT_BITS-1:0] ndig,
    input  logic [A_W-1:0]      a_mag,
    input  logic [B_W-1:0]      b_mag,
    input  logic [P_W-1:0]      addend,
    output logic                done,
    output logic [P_W-1:0]      result
);

    localparam int DW   = cbrf_pkg::DIGIT_W;
    localparam int PP_W = A_W + DW;

    cbrf_pkg::mul_state_t state_reg, state_next;
    logic [A_W-1:0]      a_reg, a_next;
    logic [B_W-1:0]      b_reg, b_next;
    logic [P_W-1:0]      addend_reg, addend_next;
    logic                neg_reg, neg_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PP_W-1:0]     prod_reg, prod_next;
    logic                pvld_reg, pvld_next;
    logic [P_W-1:0]      acc_reg, acc_next;
    logic [P_W-1:0]      result_reg, result_next;
    logic                done_reg, done_next;

    logic [DW-1:0]       digit;
    logic [P_W-1:0]      acc_sum;

    // Top digit of the multiplier and the shifted running sum.
    assign digit   = b_reg[B_W-1 -: DW];
    assign acc_sum = (acc_reg << DW) + P_W'(prod_reg);

    // Next state and datapath.
    always_comb begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        addend_next = addend_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        pvld_next   = pvld_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        case (state_reg)
            cbrf_pkg::M_IDLE: begin
                if (start) begin
                    a_next      = a_mag;
                    b_next      = b_mag;
                    addend_next = addend;
                    neg_next    = neg;
                    cnt_next    = ndig;
                    acc_next    = '0;
                    pvld_next   = 1'b0;
                    state_next  = cbrf_pkg::M_RUN;
                end
            end
            cbrf_pkg::M_RUN: begin
                // One partial product per cycle; the previous one is accumulated.
                prod_next = PP_W'(a_reg) * PP_W'(digit);
                b_next    = b_reg << DW;
                cnt_next  = cnt_reg - CNT_BITS'(1);
                pvld_next = 1'b1;
                if (pvld_reg) begin
                    acc_next = acc_sum;
                end
                if (cnt_reg == CNT_BITS'(1)) begin
                    state_next = cbrf_pkg::M_DRAIN;
                end
            end
            cbrf_pkg::M_DRAIN: begin
                acc_next   = acc_sum;
                pvld_next  = 1'b0;
                state_next = cbrf_pkg::M_FIN;
            end
            cbrf_pkg::M_FIN: begin
                // Apply the product sign while adding the addend.
                result_next = neg_reg ? (addend_reg - acc_reg) : (addend_reg + acc_reg);
                done_next   = 1'b1;
                state_next  = cbrf_pkg::M_IDLE;
            end
            default: begin
                state_next = cbrf_pkg::M_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbrf_pkg::M_IDLE;
            cnt_reg   <= '0;
            pvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pvld_reg  <= pvld_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        addend_reg <= addend_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/cbrf_poly.sv =====
// Exact sign of p(x) = c3*x^3 + c1*x + c0, scaled by 2^(4*FRAC_BITS).
// Evaluated as x*(c3*x*x + c1<<2F) + c0<<3F on the shared multiplier.
// Depends on cbrf_pkg and cbrf_mul.
module cbrf_poly #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cbrf_pkg::VAL_W-1:0]    x,
    input  cbrf_pkg::coef_t               coef,
    output logic                          done,
    output cbrf_pkg::psign_t              sign
);

    localparam int W   = cbrf_pkg::VAL_W;
    localparam int DW  = cbrf_pkg::DIGIT_W;
    // Magnitude bits of c3*x^2 + c1<<2F, and of the full sum with sign margin.
    localparam int UB0 = (3 * W > W + 2 * FRAC_BITS) ? 3 * W : W + 2 * FRAC_BITS;
    localparam int UB  = UB0 + 1;
    localparam int PW0 = (UB + W > W + 3 * FRAC_BITS) ? UB + W : W + 3 * FRAC_BITS;
    localparam int PW  = PW0 + 2;
    // Digit counts of the three multiplications.
    localparam int ND1 = (W + DW - 1) / DW;
    localparam int ND2 = (2 * W + DW - 1) / DW;
    localparam int ND3 = (UB + DW - 1) / DW;
    localparam int MB  = ND3 * DW;
    localparam int CNT_BITS = $clog2(ND3 + 1);

    cbrf_pkg::poly_state_t state_reg, state_next;
    logic [W-1:0]        x_reg, x_next;
    logic [PW-1:0]       u_reg, u_next;
    logic                done_reg, done_next;
    cbrf_pkg::psign_t    sign_reg, sign_next;

    logic                mul_start, mul_neg, mul_done;
    logic [CNT_BITS-1:0] mul_ndig;
    logic [W-1:0]        mul_a;
    logic [MB-1:0]       mul_b;
    logic [PW-1:0]       mul_addend, mul_result;

    logic [W-1:0]        x_mag, c3_mag;
    logic [PW-1:0]       u_mag, c1_ext, c0_ext;
    logic [ND1*DW-1:0]   x_dig;
    logic [ND2*DW-1:0]   t_dig;

    // Operand magnitudes and aligned addends.
    assign x_mag  = x_reg[W-1] ? (~x_reg + W'(1)) : x_reg;
    assign c3_mag = coef.cubic[W-1] ? (~coef.cubic + W'(1)) : coef.cubic;
    assign u_mag  = u_reg[PW-1] ? (~u_reg + PW'(1)) : u_reg;
    assign c1_ext = {{(PW - W){coef.linear[W-1]}}, coef.linear} << (2 * FRAC_BITS);
    assign c0_ext = {{(PW - W){coef.offset[W-1]}}, coef.offset} << (3 * FRAC_BITS);
    assign x_dig  = (ND1 * DW)'(x_mag);
    assign t_dig  = mul_result[ND2*DW-1:0];

    cbrf_mul #(
        .A_W      (W),
        .B_W      (MB),
        .P_W      (PW),
        .CNT_BITS (CNT_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .neg     (mul_neg),
        .ndig    (mul_ndig),
        .a_mag   (mul_a),
        .b_mag   (mul_b),
        .addend  (mul_addend),
        .done    (mul_done),
        .result  (mul_result)
    );

    // Sequencer: square, cube term plus linear term, magnitude, final product.
    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        u_next     = u_reg;
        sign_next  = sign_reg;
        done_next  = 1'b0;
        mul_start  = 1'b0;
        mul_neg    = 1'b0;
        mul_ndig   = CNT_BITS'(ND1);
        mul_a      = x_mag;
        mul_b      = MB'(x_dig) << (MB - ND1 * DW);
        mul_addend = '0;
        case (state_reg)
            cbrf_pkg::P_IDLE: begin
                if (start) begin
                    x_next     = x;
                    state_next = cbrf_pkg::P_LOAD;
                end
            end
            cbrf_pkg::P_LOAD: begin
                mul_start  = 1'b1;
                state_next = cbrf_pkg::P_SQ;
            end
            cbrf_pkg::P_SQ: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_neg    = coef.cubic[W-1];
                    mul_ndig   = CNT_BITS'(ND2);
                    mul_a      = c3_mag;
                    mul_b      = MB'(t_dig) << (MB - ND2 * DW);
                    mul_addend = c1_ext;
                    state_next = cbrf_pkg::P_CUBE;
                end
            end
            cbrf_pkg::P_CUBE: begin
                if (mul_done) begin
                    u_next     = mul_result;
                    state_next = cbrf_pkg::P_ABS;
                end
            end
            cbrf_pkg::P_ABS: begin
                mul_start  = 1'b1;
                mul_neg    = u_reg[PW-1] ^ x_reg[W-1];
                mul_ndig   = CNT_BITS'(ND3);
                mul_a      = x_mag;
                mul_b      = MB'(u_mag);
                mul_addend = c0_ext;
                state_next = cbrf_pkg::P_LIN;
            end
            cbrf_pkg::P_LIN: begin
                if (mul_done) begin
                    sign_next.neg  = mul_result[PW-1];
                    sign_next.zero = (mul_result == '0);
                    done_next      = 1'b1;
                    state_next     = cbrf_pkg::P_IDLE;
                end
            end
            default: begin
                state_next = cbrf_pkg::P_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbrf_pkg::P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        u_reg    <= u_next;
        sign_reg <= sign_next;
    end

    assign done = done_reg;
    assign sign = sign_reg;

endmodule

// ===== rtl/cubic_bisection_root_finder.sv =====
// Top level of the cubic bisection root finder: configuration registers,
// bisection sequencer and result register. Depends on cbrf_pkg and cbrf_poly.
//
//   Channel | Ports                                  | Moves
//   input   | s_valid, s_ready, s_data               | interval [left_end, right_end]
//   result  | m_valid, m_ready, m_data               | root and status flags
//   config  | cfg_valid, cfg_ready, cfg_index/_data  | coefficient or tolerance write
//
// Each polynomial evaluation runs on the shared 32x16 digit multiplier.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next transaction can be accepted meanwhile.
// Reset is synchronous and active low; it restores the default coefficients and tolerance.
module cubic_bisection_root_finder #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cbrf_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cbrf_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  cbrf_pkg::cfg_idx_t            cfg_index,
    input  logic [cbrf_pkg::VAL_W-1:0]    cfg_data
);

    localparam int W = cbrf_pkg::VAL_W;

    // Reset values and the not-bracketed result.
    localparam logic [W-1:0] CUBIC_RST  = W'(64'sd1 <<< FRAC_BITS);
    localparam logic [W-1:0] LINEAR_RST = W'(-(64'sd3 <<< FRAC_BITS));
    localparam logic [W-1:0] CONST_RST  = W'(-(64'sd5 <<< FRAC_BITS));
    localparam logic [cbrf_pkg::TOL_W-1:0] TOL_RST = cbrf_pkg::TOL_W'(66);
    localparam logic [W-1:0] NEG_ONE    = W'(-(64'sd1 <<< FRAC_BITS));

    cbrf_pkg::top_state_t           state_reg, state_next;
    cbrf_pkg::coef_t                coef_reg;
    logic [cbrf_pkg::TOL_W-1:0]     tol_reg;
    logic [W-1:0]                   a_reg, a_next;
    logic [W-1:0]                   b_reg, b_next;
    logic [W-1:0]                   c_reg, c_next;
    logic [cbrf_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           hit_reg, hit_next;
    logic                           nob_reg, nob_next;
    cbrf_pkg::psign_t               sa_reg, sa_next;
    logic                           m_valid_reg, m_valid_next;
    cbrf_pkg::out_item_t            m_data_reg, m_data_next;

    logic                           poly_start, poly_done;
    logic [W-1:0]                   poly_x;
    cbrf_pkg::psign_t               poly_sign;

    logic [cbrf_pkg::TOL_W-1:0]     tol_eff;
    logic signed [W:0]              diff, sum;
    logic [W-1:0]                   mid;
    logic                           wide;

    // Interval width test and floor midpoint.
    assign tol_eff = (tol_reg < cbrf_pkg::TOL_MIN) ? cbrf_pkg::TOL_MIN : tol_reg;
    assign diff    = $signed({b_reg[W-1], b_reg}) - $signed({a_reg[W-1], a_reg});
    assign sum     = $signed({b_reg[W-1], b_reg}) + $signed({a_reg[W-1], a_reg});
    assign mid     = sum[W:1];
    assign wide    = (diff >= $signed({2'b00, tol_eff}));

    cbrf_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (poly_start),
        .x       (poly_x),
        .coef    (coef_reg),
        .done    (poly_done),
        .sign    (poly_sign)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.cubic  <= CUBIC_RST;
            coef_reg.linear <= LINEAR_RST;
            coef_reg.offset <= CONST_RST;
            tol_reg         <= TOL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbrf_pkg::CFG_CUBIC:  coef_reg.cubic  <= cfg_data;
                cbrf_pkg::CFG_LINEAR: coef_reg.linear <= cfg_data;
                cbrf_pkg::CFG_CONST:  coef_reg.offset <= cfg_data;
                cbrf_pkg::CFG_TOL:    tol_reg <= cfg_data[cbrf_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Bisection sequencer: bracket check, then halve until narrow or exact.
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        nob_next     = nob_reg;
        sa_next      = sa_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        poly_start   = 1'b0;
        poly_x       = a_reg;
        case (state_reg)
            cbrf_pkg::T_IDLE: begin
                if (s_valid) begin
                    a_next     = s_data.left_end;
                    b_next     = s_data.right_end;
                    c_next     = s_data.left_end;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    nob_next   = 1'b0;
                    poly_start = 1'b1;
                    poly_x     = s_data.left_end;
                    state_next = cbrf_pkg::T_EVAL_A;
                end
            end
            cbrf_pkg::T_EVAL_A: begin
                if (poly_done) begin
                    sa_next    = poly_sign;
                    poly_start = 1'b1;
                    poly_x     = b_reg;
                    state_next = cbrf_pkg::T_EVAL_B;
                end
            end
            cbrf_pkg::T_EVAL_B: begin
                if (poly_done) begin
                    if (sa_reg.zero || poly_sign.zero || (sa_reg.neg == poly_sign.neg)) begin
                        nob_next   = 1'b1;
                        state_next = cbrf_pkg::T_DONE;
                    end else begin
                        state_next = cbrf_pkg::T_CHECK;
                    end
                end
            end
            cbrf_pkg::T_CHECK: begin
                if (wide) begin
                    c_next     = mid;
                    cnt_next   = cnt_reg + cbrf_pkg::CNT_W'(1);
                    poly_start = 1'b1;
                    poly_x     = mid;
                    state_next = cbrf_pkg::T_EVAL_C;
                end else begin
                    state_next = cbrf_pkg::T_DONE;
                end
            end
            cbrf_pkg::T_EVAL_C: begin
                if (poly_done) begin
                    if (poly_sign.zero) begin
                        hit_next   = 1'b1;
                        state_next = cbrf_pkg::T_DONE;
                    end else begin
                        if (poly_sign.neg != sa_reg.neg) begin
                            b_next = c_reg;
                        end else begin
                            a_next = c_reg;
                        end
                        state_next = cbrf_pkg::T_CHECK;
                    end
                end
            end
            cbrf_pkg::T_DONE: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_data_next.root       = nob_reg ? NEG_ONE : c_reg;
                    m_data_next.no_bracket = nob_reg;
                    m_data_next.exact_hit  = hit_reg;
                    m_data_next.halvings   = cnt_reg;
                    m_valid_next           = 1'b1;
                    state_next             = cbrf_pkg::T_IDLE;
                end
            end
            default: begin
                state_next = cbrf_pkg::T_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cbrf_pkg::T_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            nob_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
            nob_reg     <= nob_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        sa_reg     <= sa_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == cbrf_pkg::T_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule
